// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the RTL. Each expects clk and rst_n
// in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bde_pkg.sv -----
// ----------------------------------------------------------------------------
// bde_pkg
// Sizes, operation and status codes, and ring arithmetic for the deque.
// ----------------------------------------------------------------------------
`default_nettype none

package bde_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = IDX_W + 1;
    localparam int OCC_W  = 7;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_ZERO_BACK  = 3'd6,
        OP_SEARCH     = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Ring position of the entry that lies off places behind the front.
    // Both terms are below DEPTH, so one conditional subtract wraps the sum.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] front,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

    // Position one step towards the front, wrapping below zero.
    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] front);
        logic [IDX_W-1:0] pos;
        if (front == '0)
        begin
            pos = IDX_W'(DEPTH - 1);
        end
        else
        begin
            pos = front - 1'b1;
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ----- sv/bounded_deque_engine.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of 32-bit words held in a ring-buffer memory.
// ----------------------------------------------------------------------------
// Usage:
// A request word (req_type, value) is taken when req_valid is high and
// req_stall is low. Each request gives exactly one response word (data_out,
// found, status, occupancy) on the rsp channel, taken when rsp_valid is high
// and rsp_stall is low. Responses leave in request order.
// Push, zero back and every refused or empty request finish at acceptance:
// the response is loaded into the output register if it is free, and the
// next request can then be taken straight away. Pop and peek pass through
// ST_READ, as the entry memory gives registered read data. Search reads one
// entry per cycle through the single read port and ends at the first match
// (soonest for a match at the front) or after the last live entry.
// A finished response sits in the output register while the next request is
// accepted; a further finished response waits in a holding stage, and the
// request side stalls until the output register is free.
// Reset empties the deque and the output register; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bounded_deque_engine
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [2:0]          req_type,
    input  logic signed [31:0]  value,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic signed [31:0]  data_out,
    output logic                found,
    output logic [1:0]          status,
    output logic [6:0]          occupancy
);

    localparam int DEPTH  = bde_pkg::DEPTH;
    localparam int DATA_W = bde_pkg::DATA_W;
    localparam int IDX_W  = bde_pkg::IDX_W;
    localparam int CNT_W  = bde_pkg::CNT_W;
    localparam int OCC_W  = bde_pkg::OCC_W;
    localparam int STAT_W = bde_pkg::STAT_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    srch_off_reg, srch_off_next;
    logic [DATA_W-1:0]   val_reg, val_next;

    // Holding stage for a response that is complete or being completed.
    logic [DATA_W-1:0]   res_data_reg, res_data_next;
    logic                res_found_reg, res_found_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [CNT_W-1:0]    res_count_reg, res_count_next;

    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    logic                out_found_reg, out_found_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;
    logic [CNT_W-1:0]    out_count_reg, out_count_next;

    logic [DATA_W-1:0]   mem [DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic                mem_we, mem_re;
    logic [IDX_W-1:0]    mem_waddr, mem_raddr;
    logic [DATA_W-1:0]   mem_wdata;

    logic                accept;
    logic                out_free;
    logic                done;
    logic [IDX_W-1:0]    back_pos;
    bde_pkg::op_t        op;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign op        = bde_pkg::op_t'(req_type);
    assign back_pos  = bde_pkg::ring_add(front_reg, CNT_W'(count_reg - 1'b1));

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        srch_off_next   = srch_off_reg;
        val_next        = val_reg;
        res_data_next   = res_data_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = front_reg;
        mem_raddr       = front_reg;
        mem_wdata       = value;
        done            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_data_next   = '0;
                    res_found_next  = 1'b0;
                    res_status_next = bde_pkg::STAT_OK;
                    res_count_next  = count_reg;
                    if (op == bde_pkg::OP_PUSH_FRONT || op == bde_pkg::OP_PUSH_BACK)
                    begin
                        done = 1'b1;
                        if (count_reg >= CNT_W'(DEPTH))
                        begin
                            res_status_next = bde_pkg::STAT_FULL;
                        end
                        else
                        begin
                            mem_we         = 1'b1;
                            count_next     = CNT_W'(count_reg + 1'b1);
                            res_count_next = count_next;
                            if (op == bde_pkg::OP_PUSH_FRONT)
                            begin
                                front_next = bde_pkg::ring_dec(front_reg);
                                mem_waddr  = front_next;
                            end
                            else
                            begin
                                mem_waddr = bde_pkg::ring_add(front_reg, count_reg);
                            end
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = bde_pkg::STAT_EMPTY;
                        done            = 1'b1;
                    end
                    else
                    begin
                        case (op)
                            bde_pkg::OP_POP_FRONT:
                            begin
                                mem_re         = 1'b1;
                                mem_raddr      = front_reg;
                                front_next     = bde_pkg::ring_add(front_reg, CNT_W'(1));
                                count_next     = CNT_W'(count_reg - 1'b1);
                                res_count_next = count_next;
                                state_next     = ST_READ;
                            end
                            bde_pkg::OP_POP_BACK:
                            begin
                                mem_re         = 1'b1;
                                mem_raddr      = back_pos;
                                count_next     = CNT_W'(count_reg - 1'b1);
                                res_count_next = count_next;
                                state_next     = ST_READ;
                            end
                            bde_pkg::OP_PEEK_FRONT:
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = front_reg;
                                state_next = ST_READ;
                            end
                            bde_pkg::OP_PEEK_BACK:
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = back_pos;
                                state_next = ST_READ;
                            end
                            bde_pkg::OP_ZERO_BACK:
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = back_pos;
                                mem_wdata = '0;
                                done      = 1'b1;
                            end
                            bde_pkg::OP_SEARCH:
                            begin
                                mem_re        = 1'b1;
                                mem_raddr     = front_reg;
                                srch_off_next = CNT_W'(1);
                                val_next      = value;
                                state_next    = ST_SEARCH;
                            end
                            default:
                            begin
                                done = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_READ:
            begin
                res_data_next = rd_data_reg;
                done          = 1'b1;
            end
            ST_SEARCH:
            begin
                // rd_data_reg holds the entry at offset srch_off_reg - 1.
                if (rd_data_reg == val_reg)
                begin
                    res_found_next = 1'b1;
                    done           = 1'b1;
                end
                else if (srch_off_reg == count_reg)
                begin
                    done = 1'b1;
                end
                else
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = bde_pkg::ring_add(front_reg, srch_off_reg);
                    srch_off_next = CNT_W'(srch_off_reg + 1'b1);
                end
            end
            ST_FINISH:
            begin
                done = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next  = out_valid_reg && rsp_stall;
        out_data_next   = out_data_reg;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        if (done)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = res_data_next;
                out_found_next  = res_found_next;
                out_status_next = res_status_next;
                out_count_next  = res_count_next;
                state_next      = ST_IDLE;
            end
            else
            begin
                state_next = ST_FINISH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        srch_off_reg   <= srch_off_next;
        val_reg        <= val_next;
        res_data_reg   <= res_data_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        out_data_reg   <= out_data_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    // Entry memory: one write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign data_out  = out_data_reg;
    assign found     = out_found_reg;
    assign status    = out_status_reg;
    assign occupancy = OCC_W'(out_count_reg);

    `ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "entry count beyond depth")
    `ASSERT_IMPLY(a_search_span, state_reg == ST_SEARCH,
        count_reg != '0 && srch_off_reg != '0 && srch_off_reg <= count_reg,
        "search walk outside the live entries")
    `ASSERT_IMPLY(a_refused_zero, out_valid_reg && out_status_reg != bde_pkg::STAT_OK,
        out_data_reg == '0 && !out_found_reg, "refused request carries data")
    `ASSERT_NEXT(a_pop_count,
        accept && count_reg != '0 && (op == bde_pkg::OP_POP_FRONT || op == bde_pkg::OP_POP_BACK),
        count_reg == CNT_W'($past(count_reg) - 1'b1), "pop did not reduce the count")

endmodule

`default_nettype wire

// ----- verif/deque_scoreboard.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_scoreboard
// Watches the request and reply channels of the deque engine, keeps its own
// ring-buffer image of the deque, works out the reply owed for every request
// word taken and checks each reply word, field by field, in order.
// ----------------------------------------------------------------------------
module deque_scoreboard
    import bde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] value,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  logic signed [31:0] data_out,
    input  logic               found,
    input  logic [1:0]         status,
    input  logic [6:0]         occupancy,
    output int                 fail_count,
    output int                 pending,
    output int                 reply_count,
    output int                 full_count,
    output int                 empty_count,
    output int                 hit_count
);

    typedef struct packed {
        logic signed [31:0] data;
        logic               hit;
        status_t            stat;
        logic [6:0]         occ;
    } reply_t;

    logic signed [31:0] slots [DEPTH];
    int unsigned        head;
    int unsigned        live;
    reply_t             owed_replies [$];

    function automatic int unsigned slot_at(input int unsigned off);
        return (head + off) % DEPTH;
    endfunction

    // Applies one request to the deque image and returns the reply it owes.
    function automatic reply_t apply_request(input op_t op, input logic signed [31:0] v);
        reply_t      r;
        int unsigned back;
        r.data = '0;
        r.hit  = 1'b0;
        r.stat = STAT_OK;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            if (live >= DEPTH)
            begin
                r.stat = STAT_FULL;
            end
            else if (op == OP_PUSH_FRONT)
            begin
                head = (head + DEPTH - 1) % DEPTH;
                slots[head] = v;
                live++;
            end
            else
            begin
                slots[slot_at(live)] = v;
                live++;
            end
        end
        else if (live == 0)
        begin
            r.stat = STAT_EMPTY;
        end
        else
        begin
            back = slot_at(live - 1);
            case (op)
                OP_POP_FRONT:
                begin
                    r.data = slots[head];
                    head = slot_at(1);
                    live--;
                end
                OP_POP_BACK:
                begin
                    r.data = slots[back];
                    live--;
                end
                OP_PEEK_FRONT: r.data = slots[head];
                OP_PEEK_BACK:  r.data = slots[back];
                OP_ZERO_BACK:  slots[back] = '0;
                default:
                begin
                    for (int unsigned i = 0; i < live; i++)
                    begin
                        if (slots[slot_at(i)] == v)
                        begin
                            r.hit = 1'b1;
                        end
                    end
                end
            endcase
        end
        r.occ = 7'(live);
        return r;
    endfunction

    task automatic flag_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            owed_replies.delete();
            head        = 0;
            live        = 0;
            fail_count  = 0;
            pending     = 0;
            reply_count = 0;
            full_count  = 0;
            empty_count = 0;
            hit_count   = 0;
        end
        else
        begin
            // The reply side goes first: a word taken at this edge cannot
            // be answered at the same edge.
            if (rsp_valid && !rsp_stall)
            begin
                reply_count++;
                if (owed_replies.size() == 0)
                begin
                    $display("%0t: reply word with none owed, data %0h status %0d",
                             $time, data_out, status);
                    fail_count++;
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (data_out !== want.data)
                    begin
                        flag_field("data_out", want.data, data_out);
                    end
                    if (found !== want.hit)
                    begin
                        flag_field("found", 32'(want.hit), 32'(found));
                    end
                    if (status !== want.stat)
                    begin
                        flag_field("status", 32'(want.stat), 32'(status));
                    end
                    if (occupancy !== want.occ)
                    begin
                        flag_field("occupancy", 32'(want.occ), 32'(occupancy));
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                want = apply_request(op_t'(req_type), value);
                if (want.stat == STAT_FULL)
                begin
                    full_count++;
                end
                if (want.stat == STAT_EMPTY)
                begin
                    empty_count++;
                end
                if (want.hit)
                begin
                    hit_count++;
                end
                owed_replies.push_back(want);
            end
            pending = owed_replies.size();
        end
    end

endmodule

// ----- verif/bounded_deque_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_deque_engine_tb
// Drives request words into the deque engine: a short directed opening on
// the empty and nearly empty deque, then phases of random traffic that fill,
// drain and probe it, with random idling on both channels. Checking is left
// to the scoreboard beside the engine; this module gives the verdict.
// ----------------------------------------------------------------------------
module bounded_deque_engine_tb;
    import bde_pkg::*;

    localparam int TARGET_WORDS = 1800;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 100;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_PROBE} mode_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [2:0]         req_type;
    logic signed [31:0] value;
    logic               rsp_valid;
    logic               rsp_stall;
    logic signed [31:0] data_out;
    logic               found;
    logic [1:0]         status;
    logic [6:0]         occupancy;

    int fail_count;
    int pending;
    int reply_count;
    int full_count;
    int empty_count;
    int hit_count;

    int                 words_sent;
    int                 phase_count;
    int                 cycles = 0;
    logic               calm;
    logic signed [31:0] recent [16];
    int unsigned        recent_wr;

    bounded_deque_engine u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .data_out  (data_out),
        .found     (found),
        .status    (status),
        .occupancy (occupancy)
    );

    deque_scoreboard u_scoreboard
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .data_out    (data_out),
        .found       (found),
        .status      (status),
        .occupancy   (occupancy),
        .fail_count  (fail_count),
        .pending     (pending),
        .reply_count (reply_count),
        .full_count  (full_count),
        .empty_count (empty_count),
        .hit_count   (hit_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d replies owed", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return (($urandom_range(0, 1) == 0) ? 32'sd0 : -32'sd1);
            default: return $urandom;
        endcase
    endfunction

    function automatic op_t pick_op(input mode_t mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                if (r < 40) return OP_PUSH_FRONT;
                if (r < 80) return OP_PUSH_BACK;
            end
            MODE_DRAIN:
            begin
                if (r < 35) return OP_POP_FRONT;
                if (r < 70) return OP_POP_BACK;
            end
            MODE_PROBE:
            begin
                if (r < 45) return OP_SEARCH;
                if (r < 60) return OP_PEEK_FRONT;
                if (r < 75) return OP_PEEK_BACK;
                if (r < 80) return OP_ZERO_BACK;
            end
            default: ;
        endcase
        return op_t'($urandom_range(0, 7));
    endfunction

    // Presents one request word after a random gap and holds it until taken.
    // Entered and left just after a falling edge.
    task automatic send_word(input op_t op, input logic signed [31:0] v);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        req_type  = op;
        value     = v;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            recent[recent_wr] = v;
            recent_wr = (recent_wr + 1) % 16;
        end
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Reply side: a random stall before each reply word, then open until
    // one is taken.
    initial
    begin
        int k;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            k = draw_wait();
            if (k > 0)
            begin
                rsp_stall = 1'b1;
                repeat (k) @(negedge clk);
                rsp_stall = 1'b0;
            end
            @(posedge clk);
            while (!rsp_valid)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    initial
    begin
        mode_t              mode;
        int                 span;
        op_t                op;
        logic signed [31:0] v;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_type    = OP_PUSH_FRONT;
        value       = '0;
        calm        = 1'b0;
        words_sent  = 0;
        phase_count = 0;
        recent_wr   = 0;
        for (int i = 0; i < 16; i++)
        begin
            recent[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every operation other than a push is flagged on the empty deque.
        send_word(OP_POP_FRONT, 32'sd5);
        send_word(OP_POP_BACK, 32'sd5);
        send_word(OP_PEEK_FRONT, 32'sd5);
        send_word(OP_PEEK_BACK, 32'sd5);
        send_word(OP_ZERO_BACK, 32'sd5);
        send_word(OP_SEARCH, 32'sd0);
        // The first push to the front wraps the ring below position zero.
        send_word(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_word(OP_PUSH_BACK, 32'sh8000_0000);
        send_word(OP_PUSH_FRONT, 32'sd0);
        send_word(OP_PUSH_BACK, -32'sd1);
        send_word(OP_PEEK_FRONT, 32'sd0);
        send_word(OP_PEEK_BACK, 32'sd0);
        send_word(OP_SEARCH, 32'sh8000_0000);
        send_word(OP_SEARCH, 32'sd12345);
        send_word(OP_ZERO_BACK, 32'sh7FFF_FFFF);
        send_word(OP_PEEK_BACK, 32'sd0);
        send_word(OP_SEARCH, 32'sd0);
        send_word(OP_POP_BACK, 32'sd0);
        send_word(OP_POP_FRONT, 32'sd0);
        send_word(OP_POP_FRONT, 32'sd0);
        send_word(OP_POP_BACK, 32'sd0);
        send_word(OP_POP_BACK, 32'sd0);
        wait_drained();

        while (words_sent < TARGET_WORDS)
        begin
            phase_count++;
            mode = mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 130);
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < span; n++)
            begin
                op = pick_op(mode);
                if (op == OP_SEARCH && $urandom_range(0, 1) == 0)
                begin
                    v = recent[$urandom_range(0, 15)];
                end
                else
                begin
                    v = pick_value();
                end
                send_word(op, v);
            end
            // Let the engine run dry at the first phase boundary and now and
            // then after that.
            if (phase_count == 1 || $urandom_range(0, 9) < 3)
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE) @(negedge clk);
        $display("Sent %0d request words over %0d random phases; %0d replies checked.",
                 words_sent, phase_count, reply_count);
        $display("Seen: %0d pushes refused when full, %0d requests on an empty deque,",
                 full_count, empty_count);
        $display("      %0d search hits.", hit_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
